// ===== rtl/masked_patch_ssd_distance_top_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the masked patch SSD distance block
// Each macro expands to a labeled concurrent assertion in simulation and
// to nothing when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MASKED_PATCH_SSD_DISTANCE_TOP_MACROS_SVH
`define MASKED_PATCH_SSD_DISTANCE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define MPSSD_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Expression must never be true outside reset.
`define MPSSD_ASSERT_NEVER(name, clk, rst, expr, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define MPSSD_ASSERT(name, clk, rst, prop, msg)
`define MPSSD_ASSERT_NEVER(name, clk, rst, expr, msg)

`endif

`endif

// ===== rtl/mpssd_pkg.sv =====
// ---------------------------------------------------------------------------
// mpssd_pkg
// Shared constants, register indexes and interface structs for the masked
// patch SSD distance block.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mpssd_pkg;

  localparam int CHANNELS     = 3;
  localparam int CHANNEL_BITS = 8;
  localparam int PIXEL_W      = CHANNELS * CHANNEL_BITS;
  localparam int GRAD_W       = 12;
  localparam int WEIGHT_W     = 8;
  localparam int SUM_W        = 48;
  localparam int COUNT_W      = 11;
  localparam int DIST_W       = 40;

  // Datapath intermediate widths.
  localparam int CSQ_W    = 2 * CHANNEL_BITS;
  localparam int CHSUM_W  = CSQ_W + 2;
  localparam int GABS_W   = GRAD_W;
  localparam int GSQ_W    = 2 * GABS_W;
  localparam int GSUM_W   = GSQ_W + 1;
  localparam int WTERM_W  = GSUM_W + WEIGHT_W;
  localparam int TERM_W   = WTERM_W + 1;
  localparam int DIVCNT_W = $clog2(SUM_W);

  // Configuration port.
  localparam int ADDR_W     = 6;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_PARTIAL_MODE     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_USE_GRADIENT     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GRAD_WEIGHT      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_ENABLE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_THRESHOLD        = 3'd4;

  localparam logic [WEIGHT_W-1:0] GRAD_WEIGHT_RESET = 8'd50;

  typedef struct packed {
    logic                partial_mode;
    logic                use_gradient;
    logic [WEIGHT_W-1:0] grad_weight;
    logic                threshold_enable;
    logic [DIST_W-1:0]   threshold;
  } cfg_t;

  typedef struct packed {
    logic in_accept;
    logic start_div;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic pipe_empty;
    logic quot_valid;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/mpssd_ctrl.sv =====
// ---------------------------------------------------------------------------
// mpssd_ctrl
// Controller: accepts positions, drains the accumulate pipeline after the
// last one, runs the divider and hands the result to the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpssd_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                s_tvalid,
  input  wire                s_tlast,
  output logic               s_tready,
  input  mpssd_pkg::status_t status,
  output mpssd_pkg::cmd_t    cmd
);
  import mpssd_pkg::*;

  localparam logic [1:0] ST_ACCUM = 2'd0;
  localparam logic [1:0] ST_DRAIN = 2'd1;
  localparam logic [1:0] ST_DIV   = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    cmd.in_accept = 1'b0;
    cmd.start_div = 1'b0;
    cmd.load_out  = 1'b0;
    case (state)
      ST_ACCUM: begin
        s_tready      = 1'b1;
        cmd.in_accept = s_tvalid;
        if (s_tvalid && s_tlast) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Wait until the last position has reached the accumulator.
        if (status.pipe_empty) begin
          cmd.start_div = 1'b1;
          state_next    = ST_DIV;
        end
      end
      ST_DIV: begin
        if (status.quot_valid && status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mpssd_dp.sv =====
// ---------------------------------------------------------------------------
// mpssd_dp
// Datapath: squared differences pipeline, saturating accumulator and
// position count, bit-serial divider and output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "masked_patch_ssd_distance_top_macros.svh"

module mpssd_dp (
  input  wire                                         clk,
  input  wire                                         rst,
  input  mpssd_pkg::cfg_t                             cfg,
  input  mpssd_pkg::cmd_t                             cmd,
  output mpssd_pkg::status_t                          status,
  input  wire        [mpssd_pkg::PIXEL_W-1:0]         pixel_a,
  input  wire        [mpssd_pkg::PIXEL_W-1:0]         pixel_b,
  input  wire signed [mpssd_pkg::GRAD_W-1:0]          grad_a_x,
  input  wire signed [mpssd_pkg::GRAD_W-1:0]          grad_a_y,
  input  wire signed [mpssd_pkg::GRAD_W-1:0]          grad_b_x,
  input  wire signed [mpssd_pkg::GRAD_W-1:0]          grad_b_y,
  input  wire                                         in_bounds,
  input  wire                                         occluded,
  output logic       [mpssd_pkg::DIST_W-1:0]          distance,
  output logic                                        rejected,
  output logic                                        out_valid,
  input  wire                                         out_ready
);
  import mpssd_pkg::*;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Stage 1: squares.
  logic [CHSUM_W-1:0] chan_sum_c;
  logic [GABS_W-1:0]  gx_abs;
  logic [GABS_W-1:0]  gy_abs;
  logic [GRAD_W:0]    gx_diff;
  logic [GRAD_W:0]    gy_diff;
  logic               counts_c;

  logic               v1;
  logic               cnt1;
  logic               grad1;
  logic [CHSUM_W-1:0] chan_sum1;
  logic [GSQ_W-1:0]   gx_sq1;
  logic [GSQ_W-1:0]   gy_sq1;

  // Stage 2: weighted gradient term and total.
  logic [GSUM_W-1:0]  gsum_c;
  logic [WTERM_W-1:0] wterm_c;
  logic               v2;
  logic               cnt2;
  logic [TERM_W-1:0]  term2;

  // Accumulator.
  logic [SUM_W-1:0]   sum_acc;
  logic [SUM_W:0]     sum_wide;
  logic [COUNT_W-1:0] position_count;

  // Divider.
  logic               div_busy;
  logic [DIVCNT_W-1:0] div_cnt;
  logic [SUM_W-1:0]   quot;
  logic [COUNT_W-1:0] rem;
  logic [COUNT_W-1:0] divisor;
  logic [COUNT_W:0]   rem_sh;
  logic [COUNT_W:0]   rem_diff;
  logic               quot_valid;
  logic [DIST_W-1:0]  dist_sat;

  always_comb begin
    chan_sum_c = '0;
    for (int c = 0; c < CHANNELS; c++) begin
      logic [CHANNEL_BITS-1:0] va;
      logic [CHANNEL_BITS-1:0] vb;
      logic [CHANNEL_BITS-1:0] d;
      va = pixel_a[c*CHANNEL_BITS +: CHANNEL_BITS];
      vb = pixel_b[c*CHANNEL_BITS +: CHANNEL_BITS];
      d  = (va > vb) ? (va - vb) : (vb - va);
      chan_sum_c = chan_sum_c + CHSUM_W'(d) * CHSUM_W'(d);
    end
  end

  // Difference of two 12-bit signed values needs 13 bits; its magnitude fits 12.
  assign gx_diff  = {grad_a_x[GRAD_W-1], grad_a_x} - {grad_b_x[GRAD_W-1], grad_b_x};
  assign gy_diff  = {grad_a_y[GRAD_W-1], grad_a_y} - {grad_b_y[GRAD_W-1], grad_b_y};
  assign gx_abs   = gx_diff[GRAD_W] ? GABS_W'(-gx_diff) : gx_diff[GABS_W-1:0];
  assign gy_abs   = gy_diff[GRAD_W] ? GABS_W'(-gy_diff) : gy_diff[GABS_W-1:0];
  assign counts_c = in_bounds && !(cfg.partial_mode && occluded);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= cmd.in_accept;
    end
    cnt1      <= counts_c;
    grad1     <= cfg.use_gradient;
    chan_sum1 <= chan_sum_c;
    gx_sq1    <= GSQ_W'(gx_abs) * GSQ_W'(gx_abs);
    gy_sq1    <= GSQ_W'(gy_abs) * GSQ_W'(gy_abs);
  end

  assign gsum_c  = GSUM_W'(gx_sq1) + GSUM_W'(gy_sq1);
  assign wterm_c = WTERM_W'(gsum_c) * WTERM_W'(cfg.grad_weight);

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    cnt2 <= cnt1;
    if (!cnt1) begin
      term2 <= '0;
    end else if (grad1) begin
      term2 <= TERM_W'(chan_sum1) + TERM_W'(wterm_c);
    end else begin
      term2 <= TERM_W'(chan_sum1);
    end
  end

  assign sum_wide = {1'b0, sum_acc} + (SUM_W + 1)'(term2);

  always_ff @(posedge clk) begin
    if (rst || cmd.start_div) begin
      sum_acc        <= '0;
      position_count <= '0;
    end else if (v2 && cnt2) begin
      sum_acc <= sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
      if (position_count != COUNT_MAX) begin
        position_count <= position_count + 1'b1;
      end
    end
  end

  // Restoring division, one quotient bit per cycle; the dividend shifts out
  // of the top of quot while quotient bits shift in at the bottom.
  assign rem_sh   = {rem, quot[SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy   <= 1'b0;
      quot_valid <= 1'b0;
      div_cnt    <= '0;
    end else if (cmd.start_div) begin
      div_busy   <= 1'b1;
      quot_valid <= 1'b0;
      div_cnt    <= DIVCNT_W'(SUM_W - 1);
    end else if (div_busy) begin
      div_cnt <= div_cnt - 1'b1;
      if (div_cnt == '0) begin
        div_busy   <= 1'b0;
        quot_valid <= 1'b1;
      end
    end else if (cmd.load_out) begin
      quot_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      quot    <= sum_acc;
      rem     <= '0;
      divisor <= (position_count == '0) ? COUNT_W'(1) : position_count;
    end else if (div_busy) begin
      if (!rem_diff[COUNT_W]) begin
        rem  <= rem_diff[COUNT_W-1:0];
        quot <= {quot[SUM_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[COUNT_W-1:0];
        quot <= {quot[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign dist_sat = (quot[SUM_W-1:DIST_W] != '0) ? {DIST_W{1'b1}} : quot[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load_out) begin
      distance <= dist_sat;
      rejected <= cfg.threshold_enable && (dist_sat > cfg.threshold);
    end
  end

  assign status.pipe_empty = !v1 && !v2;
  assign status.quot_valid = quot_valid;
  assign status.out_free   = !out_valid || out_ready;

  `MPSSD_ASSERT_NEVER(a_start_pipe_busy, clk, rst, cmd.start_div && (v1 || v2), "division started with positions still in flight")
  `MPSSD_ASSERT_NEVER(a_load_early, clk, rst, cmd.load_out && (!quot_valid || div_busy), "result loaded before the quotient was ready")
  `MPSSD_ASSERT(a_start_clears, clk, rst, cmd.start_div |=> (sum_acc == '0 && position_count == '0 && div_busy), "accumulator not cleared or divider not started")
  `MPSSD_ASSERT_NEVER(a_accept_while_div, clk, rst, cmd.in_accept && (div_busy || quot_valid), "position accepted while a division is pending")

endmodule

`default_nettype wire

// ===== rtl/masked_patch_ssd_distance_top.sv =====
// Result path: after the last position is accepted it drains through the Stage 1 and
// Stage 2 registers, then the divider runs and its result is loaded for output.
// Throughput: one position per cycle within a patch; no new patch is accepted until
// the result is loaded, and the bit-serial divider produces one quotient bit per cycle.
// Reset: clears the accumulator, position count and handshake state, and returns all
// registers to their reset values (grad_weight to 50, the others to zero).
// ---------------------------------------------------------------------------
// masked_patch_ssd_distance_top
// Masked patch sum-of-squared-differences distance with APB configuration,
// stream input of patch positions and stream output of normalized distance.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module masked_patch_ssd_distance_top (
  input  wire                                 clk,
  input  wire                                 rst,
  // APB configuration port
  input  wire                                 psel,
  input  wire                                 penable,
  input  wire                                 pwrite,
  input  wire  [mpssd_pkg::ADDR_W-1:0]        paddr,
  input  wire  [mpssd_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [mpssd_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready,
  // Position stream
  input  wire                                 s_tvalid,
  output logic                                s_tready,
  // pixel_a[23:0], pixel_b[47:24], grad_a_x[59:48], grad_a_y[71:60],
  // grad_b_x[83:72], grad_b_y[95:84]
  input  wire  [95:0]                         s_tdata,
  // in_bounds[0], occluded[1]
  input  wire  [1:0]                          s_tuser,
  input  wire                                 s_tlast,
  // Distance stream
  output logic                                m_tvalid,
  input  wire                                 m_tready,
  // distance[39:0]
  output logic [39:0]                         m_tdata,
  // rejected[0]
  output logic [0:0]                          m_tuser
);
  import mpssd_pkg::*;

  cfg_t                 cfg;
  cmd_t                 cmd;
  status_t              status;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[ADDR_W-1:ADDR_W-REG_IDX_W];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.partial_mode     <= 1'b0;
      cfg.use_gradient     <= 1'b0;
      cfg.grad_weight      <= GRAD_WEIGHT_RESET;
      cfg.threshold_enable <= 1'b0;
      cfg.threshold        <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_PARTIAL_MODE:     cfg.partial_mode     <= pwdata[0];
        REG_USE_GRADIENT:     cfg.use_gradient     <= pwdata[0];
        REG_GRAD_WEIGHT:      cfg.grad_weight      <= pwdata[WEIGHT_W-1:0];
        REG_THRESHOLD_ENABLE: cfg.threshold_enable <= pwdata[0];
        REG_THRESHOLD:        cfg.threshold        <= pwdata[DIST_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_PARTIAL_MODE:     prdata = APB_DATA_W'(cfg.partial_mode);
      REG_USE_GRADIENT:     prdata = APB_DATA_W'(cfg.use_gradient);
      REG_GRAD_WEIGHT:      prdata = APB_DATA_W'(cfg.grad_weight);
      REG_THRESHOLD_ENABLE: prdata = APB_DATA_W'(cfg.threshold_enable);
      REG_THRESHOLD:        prdata = APB_DATA_W'(cfg.threshold);
      default:              prdata = '0;
    endcase
  end

  mpssd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mpssd_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .status    (status),
    .pixel_a   (s_tdata[23:0]),
    .pixel_b   (s_tdata[47:24]),
    .grad_a_x  (s_tdata[59:48]),
    .grad_a_y  (s_tdata[71:60]),
    .grad_b_x  (s_tdata[83:72]),
    .grad_b_y  (s_tdata[95:84]),
    .in_bounds (s_tuser[0]),
    .occluded  (s_tuser[1]),
    .distance  (m_tdata),
    .rejected  (m_tuser[0]),
    .out_valid (m_tvalid),
    .out_ready (m_tready)
  );

endmodule

`default_nettype wire
